[src/ccs_pkg.sv]
// Package for the color channel suppressor: pixel payload types, register
// indexes and fixed-point constants. No dependencies.
`default_nettype none

package ccs_pkg;

	// 2.16 fixed point strengths, 16 fraction bits
	localparam int unsigned FP_SHIFT = 16;
	localparam int unsigned CHAN_W = 8;
	localparam int unsigned STRENGTH_W = 18;
	localparam int unsigned CFG_INDEX_W = 2;

	typedef logic [CHAN_W-1:0] chan_t;
	typedef logic [STRENGTH_W-1:0] strength_t;
	typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

	// register indexes on the configuration channel
	localparam cfg_index_t REG_RED_STRENGTH = 2'd0;
	localparam cfg_index_t REG_GREEN_STRENGTH = 2'd1;
	localparam cfg_index_t REG_BLUE_STRENGTH = 2'd2;

	typedef struct packed {
		chan_t red_in;
		chan_t green_in;
		chan_t blue_in;
		chan_t alpha_in;
		logic frame_end_in;
	} pixel_in_t;

	typedef struct packed {
		chan_t red_out;
		chan_t green_out;
		chan_t blue_out;
		chan_t alpha_out;
		logic frame_end_out;
	} pixel_out_t;

endpackage

`default_nettype wire

[src/ccs_chan.sv]
// One color channel of the suppressor: pull the channel toward the larger
// of the other two. Combinational. Depends on ccs_pkg.
`default_nettype none

module ccs_chan (
	input  var ccs_pkg::chan_t     chan,
	input  var ccs_pkg::chan_t     other_a,
	input  var ccs_pkg::chan_t     other_b,
	input  var ccs_pkg::strength_t strength,
	output ccs_pkg::chan_t         chan_out
);

	localparam int unsigned PROD_W = ccs_pkg::STRENGTH_W + ccs_pkg::CHAN_W;

	ccs_pkg::chan_t    ref_val;
	ccs_pkg::chan_t    excess;
	logic              above;
	logic [PROD_W-1:0] prod;
	logic [PROD_W-1:0] scaled_chan;
	logic [PROD_W-1:0] sum;
	logic              negative;

	// reference is the larger of the other two channels
	assign ref_val = (other_a > other_b) ? other_a : other_b;
	assign above   = chan > ref_val;
	assign excess  = chan - ref_val;

	// chan*(1-s) + ref*s == chan - s*(chan-ref), in 10.16
	assign prod        = PROD_W'(strength) * PROD_W'(excess);
	assign scaled_chan = PROD_W'({chan, {ccs_pkg::FP_SHIFT{1'b0}}});
	assign negative    = prod > scaled_chan;
	assign sum         = scaled_chan - prod;

	// the sum never exceeds chan, so only the low clamp can apply
	always_comb begin
		if (!above) begin
			chan_out = chan;
		end else if (negative) begin
			chan_out = '0;
		end else begin
			chan_out = sum[ccs_pkg::FP_SHIFT +: ccs_pkg::CHAN_W];
		end
	end

endmodule

`default_nettype wire

[src/colour_channel_suppressor.sv]
// Color channel suppressor top level: strength registers, input register,
// three channel units and the result register. Depends on ccs_pkg, ccs_chan.
// A pixel transferred on start passes the input register, then the result
// register, and shows on result with done high. Throughput: one pixel per
// clock; busy is always low, the result side cannot stall. Reset clears the
// strength registers and the valid flags.
`default_nettype none

module colour_channel_suppressor (
	input  var logic                 clk,
	input  var logic                 arst_n,
	input  var logic                 start,
	output logic                     busy,
	input  var ccs_pkg::pixel_in_t   src_pixel,
	output logic                     done,
	output ccs_pkg::pixel_out_t      result,
	input  var logic                 cfg_valid,
	output logic                     cfg_ready,
	input  var ccs_pkg::cfg_index_t  cfg_index,
	input  var ccs_pkg::strength_t   cfg_data
);

	ccs_pkg::strength_t  red_strength_q;
	ccs_pkg::strength_t  green_strength_q;
	ccs_pkg::strength_t  blue_strength_q;

	logic                valid_s1;
	ccs_pkg::pixel_in_t  pixel_s1;
	logic                valid_s2;
	ccs_pkg::pixel_out_t pixel_s2;
	ccs_pkg::pixel_out_t next_out;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// write strength registers on a config transfer; ignore unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_strength_q   <= '0;
			green_strength_q <= '0;
			blue_strength_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				ccs_pkg::REG_RED_STRENGTH:   red_strength_q   <= cfg_data;
				ccs_pkg::REG_GREEN_STRENGTH: green_strength_q <= cfg_data;
				ccs_pkg::REG_BLUE_STRENGTH:  blue_strength_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// capture the input pixel on a transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			pixel_s1 <= src_pixel;
		end
	end

	// suppress each color channel against the other two
	ccs_chan u_red (
		.chan     (pixel_s1.red_in),
		.other_a  (pixel_s1.green_in),
		.other_b  (pixel_s1.blue_in),
		.strength (red_strength_q),
		.chan_out (next_out.red_out)
	);

	ccs_chan u_green (
		.chan     (pixel_s1.green_in),
		.other_a  (pixel_s1.red_in),
		.other_b  (pixel_s1.blue_in),
		.strength (green_strength_q),
		.chan_out (next_out.green_out)
	);

	ccs_chan u_blue (
		.chan     (pixel_s1.blue_in),
		.other_a  (pixel_s1.red_in),
		.other_b  (pixel_s1.green_in),
		.strength (blue_strength_q),
		.chan_out (next_out.blue_out)
	);

	// pass alpha and the frame end mark
	assign next_out.alpha_out     = pixel_s1.alpha_in;
	assign next_out.frame_end_out = pixel_s1.frame_end_in;

	// register the result; the strobe lasts one cycle per pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			pixel_s2 <= next_out;
		end
	end

	assign done   = valid_s2;
	assign result = pixel_s2;

endmodule

`default_nettype wire

[src/ccs_checker.sv]
// Port-level checks for the color channel suppressor and their bind to the
// top level. Depends on ccs_pkg and colour_channel_suppressor.
`default_nettype none

module ccs_checker (
	input var logic                clk,
	input var logic                arst_n,
	input var logic                start,
	input var logic                busy,
	input var ccs_pkg::pixel_in_t  src_pixel,
	input var logic                done,
	input var ccs_pkg::pixel_out_t result
);

	// the block never holds off a pixel
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	// every result comes from a pixel transferred through the input and result registers
	a_done_from_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("result without a matching input transfer");

	// alpha and frame end travel with their pixel
	a_alpha_pass: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.alpha_out == $past(src_pixel.alpha_in, 2)))
		else $error("alpha altered");

	a_frame_end_pass: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.frame_end_out == $past(src_pixel.frame_end_in, 2)))
		else $error("frame end mark altered");

	// suppression only ever lowers a channel
	a_red_not_raised: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.red_out <= $past(src_pixel.red_in, 2)))
		else $error("red raised by suppression");

endmodule

bind colour_channel_suppressor ccs_checker u_ccs_checker (.*);

`default_nettype wire

[dv/testbench.sv]
// Self-checking testbench for colour_channel_suppressor: directed and random pixels
// against a built-in predictor of the spill suppression math.
// Depends on ccs_pkg and the colour_channel_suppressor RTL.
`default_nettype none

module testbench;

	localparam longint FP_ONE = longint'(1) <<< ccs_pkg::FP_SHIFT;
	localparam longint CHAN_MAX = 255;
	localparam ccs_pkg::strength_t STRENGTH_MAX = '1;
	localparam ccs_pkg::cfg_index_t REG_UNUSED = 2'd3;
	localparam int LATENCY_CYCLES = 2;
	localparam int DRAIN_LIMIT = 64;
	localparam int PHASE_PIXELS = 105;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	ccs_pkg::pixel_in_t src_pixel;
	logic done;
	ccs_pkg::pixel_out_t result;
	logic cfg_valid;
	logic cfg_ready;
	ccs_pkg::cfg_index_t cfg_index;
	ccs_pkg::strength_t cfg_data;

	// strengths as the block should hold them, indexed by register index
	ccs_pkg::strength_t channel_strength [0:2];
	ccs_pkg::pixel_out_t predicted_pixels [$];
	int mismatch_count;

	colour_channel_suppressor i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.src_pixel(src_pixel),
		.done(done),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// end the run if the pixel stream stalls
	initial begin
		#2000000;
		$display("Verification failed");
		$finish;
	end

	// pull one channel toward its reference by the given 2.16 amount
	function automatic ccs_pkg::chan_t pull_channel(ccs_pkg::chan_t level,
		ccs_pkg::chan_t reference, ccs_pkg::strength_t amount);
		longint weighted;
		longint scaled;
		if (level <= reference)
			return level;
		weighted = longint'(level) * (FP_ONE - longint'(amount))
			+ longint'(reference) * longint'(amount);
		if (weighted < 0)
			return '0;
		scaled = weighted >>> ccs_pkg::FP_SHIFT;
		if (scaled > CHAN_MAX)
			scaled = CHAN_MAX;
		return ccs_pkg::chan_t'(scaled);
	endfunction

	function automatic ccs_pkg::pixel_out_t suppress_pixel(ccs_pkg::pixel_in_t pix);
		ccs_pkg::pixel_out_t out;
		ccs_pkg::chan_t red_ref;
		ccs_pkg::chan_t green_ref;
		ccs_pkg::chan_t blue_ref;
		red_ref = (pix.green_in > pix.blue_in) ? pix.green_in : pix.blue_in;
		green_ref = (pix.red_in > pix.blue_in) ? pix.red_in : pix.blue_in;
		blue_ref = (pix.red_in > pix.green_in) ? pix.red_in : pix.green_in;
		out.red_out = pull_channel(pix.red_in, red_ref,
			channel_strength[ccs_pkg::REG_RED_STRENGTH]);
		out.green_out = pull_channel(pix.green_in, green_ref,
			channel_strength[ccs_pkg::REG_GREEN_STRENGTH]);
		out.blue_out = pull_channel(pix.blue_in, blue_ref,
			channel_strength[ccs_pkg::REG_BLUE_STRENGTH]);
		out.alpha_out = pix.alpha_in;
		out.frame_end_out = pix.frame_end_in;
		return out;
	endfunction

	function automatic ccs_pkg::pixel_in_t make_pixel(int r, int g, int b, int a, bit fe);
		ccs_pkg::pixel_in_t pix;
		pix.red_in = ccs_pkg::chan_t'(r);
		pix.green_in = ccs_pkg::chan_t'(g);
		pix.blue_in = ccs_pkg::chan_t'(b);
		pix.alpha_in = ccs_pkg::chan_t'(a);
		pix.frame_end_in = fe;
		return pix;
	endfunction

	// mix of noise, spill-like pixels, near ties and extremes
	function automatic ccs_pkg::pixel_in_t random_pixel();
		int kind;
		int base;
		int lead;
		int chan [3];
		kind = $urandom_range(0, 9);
		base = $urandom_range(1, 254);
		for (int i = 0; i < 3; i++) begin
			case (kind)
				3, 4, 5: chan[i] = $urandom_range(0, 200);
				6, 7: chan[i] = base + $urandom_range(0, 2) - 1;
				8: chan[i] = $urandom_range(0, 1) ? 255 : 0;
				9: chan[i] = base;
				default: chan[i] = $urandom_range(0, 255);
			endcase
		end
		// give one channel a clear lead
		if (kind >= 3 && kind <= 5) begin
			lead = $urandom_range(0, 2);
			chan[lead] = $urandom_range(chan[lead], 255);
		end
		return make_pixel(chan[0], chan[1], chan[2], $urandom_range(0, 255),
			$urandom_range(0, 15) == 0);
	endfunction

	function automatic ccs_pkg::strength_t random_strength();
		case ($urandom_range(0, 3))
			0: return ccs_pkg::strength_t'($urandom_range(0, int'(2 * FP_ONE)));
			1: return ccs_pkg::strength_t'($urandom_range(0, int'(STRENGTH_MAX)));
			2: return ccs_pkg::strength_t'($urandom_range(int'(FP_ONE - 8),
				int'(FP_ONE + 8)));
			default: begin
				case ($urandom_range(0, 5))
					0: return '0;
					1: return ccs_pkg::strength_t'(1);
					2: return ccs_pkg::strength_t'(FP_ONE - 1);
					3: return ccs_pkg::strength_t'(FP_ONE);
					4: return ccs_pkg::strength_t'(2 * FP_ONE);
					default: return STRENGTH_MAX;
				endcase
			end
		endcase
	endfunction

	// mostly back to back, some short gaps, a few long ones
	function automatic int gap_length();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic report_mismatch(string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
	endtask

	// present one pixel and hold it until the block takes it
	task automatic send_pixel(ccs_pkg::pixel_in_t pix);
		@(negedge clk);
		start <= 1'b1;
		src_pixel <= pix;
		do @(posedge clk); while (busy);
		predicted_pixels.push_back(suppress_pixel(pix));
	endtask

	task automatic idle_cycles(int count);
		if (count == 0)
			return;
		@(negedge clk);
		start <= 1'b0;
		src_pixel <= random_pixel();
		repeat (count - 1) @(negedge clk);
	endtask

	// stop sending and wait for every pending pixel to come back
	task automatic drain_results();
		int waited;
		@(negedge clk);
		start <= 1'b0;
		waited = 0;
		while (predicted_pixels.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (LATENCY_CYCLES + 2) @(posedge clk);
		if (predicted_pixels.size() != 0) begin
			report_mismatch($sformatf("%0d pixels never came back", predicted_pixels.size()));
			predicted_pixels.delete();
		end
	endtask

	task automatic write_register(ccs_pkg::cfg_index_t idx, ccs_pkg::strength_t value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		if (idx <= ccs_pkg::REG_BLUE_STRENGTH)
			channel_strength[idx] = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic apply_strengths(ccs_pkg::strength_t red, ccs_pkg::strength_t green,
		ccs_pkg::strength_t blue);
		drain_results();
		write_register(ccs_pkg::REG_RED_STRENGTH, red);
		write_register(ccs_pkg::REG_GREEN_STRENGTH, green);
		write_register(ccs_pkg::REG_BLUE_STRENGTH, blue);
	endtask

	task automatic run_pixels(int count, bit with_gaps);
		for (int i = 0; i < count; i++) begin
			send_pixel(random_pixel());
			if (with_gaps)
				idle_cycles(gap_length());
		end
	endtask

	// reset strengths are zero, so every channel passes through
	task automatic test_reset_passthrough();
		send_pixel(make_pixel(255, 0, 0, 0, 1'b1));
		send_pixel(make_pixel(0, 255, 0, 255, 1'b0));
		idle_cycles(2);
		send_pixel(make_pixel(0, 0, 255, 128, 1'b1));
		send_pixel(make_pixel(37, 200, 90, 1, 1'b0));
	endtask

	// unity, double and out-of-range strengths, ties and full-scale pixels
	task automatic test_strength_corners();
		apply_strengths(ccs_pkg::strength_t'(FP_ONE), ccs_pkg::strength_t'(2 * FP_ONE),
			STRENGTH_MAX);
		// unused index must leave every strength alone
		write_register(REG_UNUSED, STRENGTH_MAX);
		write_register(REG_UNUSED, '0);
		send_pixel(make_pixel(255, 0, 0, 255, 1'b0));
		send_pixel(make_pixel(0, 255, 0, 0, 1'b1));
		send_pixel(make_pixel(0, 10, 255, 17, 1'b0));
		send_pixel(make_pixel(200, 200, 200, 99, 1'b0));
		send_pixel(make_pixel(255, 255, 0, 3, 1'b0));
		idle_cycles(1);
		send_pixel(make_pixel(0, 255, 255, 250, 1'b1));
		send_pixel(make_pixel(255, 0, 255, 128, 1'b0));
		send_pixel(make_pixel(0, 0, 0, 0, 1'b0));
		send_pixel(make_pixel(255, 255, 255, 255, 1'b1));
		send_pixel(make_pixel(100, 50, 80, 64, 1'b0));
		send_pixel(make_pixel(50, 100, 80, 192, 1'b0));
		send_pixel(make_pixel(90, 60, 200, 85, 1'b1));
	endtask

	// fractional strengths that exercise the floor of the shift
	task automatic test_fractional_strengths();
		apply_strengths(ccs_pkg::strength_t'(1), ccs_pkg::strength_t'(FP_ONE / 2),
			ccs_pkg::strength_t'(FP_ONE - 1));
		send_pixel(make_pixel(255, 0, 0, 170, 1'b0));
		send_pixel(make_pixel(0, 255, 0, 85, 1'b0));
		send_pixel(make_pixel(0, 0, 255, 42, 1'b1));
		send_pixel(make_pixel(255, 254, 0, 213, 1'b0));
		send_pixel(make_pixel(1, 3, 2, 7, 1'b1));
	endtask

	// random pixels under a series of strength settings
	task automatic test_random_settings();
		apply_strengths('0, '0, '0);
		run_pixels(PHASE_PIXELS, 1'b1);
		apply_strengths(ccs_pkg::strength_t'(FP_ONE), ccs_pkg::strength_t'(FP_ONE),
			ccs_pkg::strength_t'(FP_ONE));
		run_pixels(PHASE_PIXELS, 1'b0);
		apply_strengths(ccs_pkg::strength_t'(2 * FP_ONE), ccs_pkg::strength_t'(2 * FP_ONE),
			ccs_pkg::strength_t'(2 * FP_ONE));
		run_pixels(PHASE_PIXELS, 1'b1);
		apply_strengths(STRENGTH_MAX, STRENGTH_MAX, STRENGTH_MAX);
		run_pixels(PHASE_PIXELS, 1'b1);
		repeat (4) begin
			apply_strengths(random_strength(), random_strength(), random_strength());
			run_pixels(PHASE_PIXELS, 1'b1);
		end
	endtask

	// compare each result with the oldest prediction
	always @(posedge clk) begin
		ccs_pkg::pixel_out_t want;
		if (arst_n && done) begin
			if (predicted_pixels.size() == 0) begin
				report_mismatch("result with no pixel pending");
			end else begin
				want = predicted_pixels.pop_front();
				check_field("red", result.red_out, want.red_out);
				check_field("green", result.green_out, want.green_out);
				check_field("blue", result.blue_out, want.blue_out);
				check_field("alpha", result.alpha_out, want.alpha_out);
				check_field("frame_end", 8'(result.frame_end_out), 8'(want.frame_end_out));
			end
		end
	end

	initial begin
		mismatch_count = 0;
		arst_n = 1'b0;
		start = 1'b0;
		src_pixel = '0;
		cfg_valid = 1'b0;
		cfg_index = ccs_pkg::REG_RED_STRENGTH;
		cfg_data = '0;
		channel_strength[ccs_pkg::REG_RED_STRENGTH] = '0;
		channel_strength[ccs_pkg::REG_GREEN_STRENGTH] = '0;
		channel_strength[ccs_pkg::REG_BLUE_STRENGTH] = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_passthrough();
		test_strength_corners();
		test_fractional_strengths();
		test_random_settings();
		drain_results();

		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

`default_nettype wire

[colour_channel_suppressor.f]
src/ccs_pkg.sv
src/ccs_chan.sv
src/colour_channel_suppressor.sv
src/ccs_checker.sv
dv/testbench.sv
